FILE: rtl/lrbt_pkg.sv
// ----------------------------------------------------------------------------
// lrbt_pkg: shared constants and types for the register binding table
// Table geometry, field widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lrbt_pkg;

   localparam int NUM_REGS      = 22;
   localparam int VAR_ID_BITS   = 16;
   localparam int SCOPE_ID_BITS = 8;
   localparam int STAMP_BITS    = 32;

   localparam int IDX_BITS     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CNT_BITS     = $clog2(NUM_REGS + 1);
   localparam int REG_OUT_BITS = 5;

   localparam int IN_FIELD_BITS = VAR_ID_BITS + SCOPE_ID_BITS;
   localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
   localparam int OUT_FIELD_BITS = 3 * 1 + 2 * REG_OUT_BITS;
   localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request, clear scan trackers
      logic step;     // examine one entry
      logic commit;   // update table, load result register
   } lrbt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;  // current scan entry is the last one
      logic rsp_busy;   // result register holds an untaken transfer
   } lrbt_status_type;

endpackage

FILE: rtl/lrbt_ctrl.sv
// ----------------------------------------------------------------------------
// lrbt_ctrl: request sequencer
// Accepts a request, runs one scan over all entries, then commits the update.
// ----------------------------------------------------------------------------
module lrbt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  lrbt_pkg::lrbt_status_type status,
   output lrbt_pkg::lrbt_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // wait for the previous result to leave
            if (!status.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: rtl/lrbt_datapath.sv
// ----------------------------------------------------------------------------
// lrbt_datapath: binding table storage, scan trackers and result register
// One entry per scan step: match, first free, oldest temporary, oldest entry.
// ----------------------------------------------------------------------------
module lrbt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lrbt_pkg::lrbt_cmd_type               cmd,
   output lrbt_pkg::lrbt_status_type            status,
   input  logic [lrbt_pkg::IN_DATA_BITS-1:0]    req_tdata,
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lrbt_pkg::OUT_DATA_BITS-1:0]   rsp_tdata
);

   localparam int N   = lrbt_pkg::NUM_REGS;
   localparam int IB  = lrbt_pkg::IDX_BITS;
   localparam int VB  = lrbt_pkg::VAR_ID_BITS;
   localparam int SB  = lrbt_pkg::SCOPE_ID_BITS;
   localparam int TB  = lrbt_pkg::STAMP_BITS;
   localparam int CB  = lrbt_pkg::CNT_BITS;
   localparam int RB  = lrbt_pkg::REG_OUT_BITS;
   localparam int OUT_DATA_BITS_L = lrbt_pkg::OUT_DATA_BITS;

   // table
   logic          ent_valid_ff [N];
   logic          ent_temp_ff  [N];
   logic [TB-1:0] ent_stamp_ff [N];
   logic [VB-1:0] ent_var_ff   [N];
   logic [SB-1:0] ent_scope_ff [N];

   logic [TB-1:0] use_clock_ff;
   logic [CB-1:0] occ_ff;

   // captured request
   logic          rq_temp_ff;
   logic [VB-1:0] rq_var_ff;
   logic [SB-1:0] rq_scope_ff;

   // scan trackers
   logic [IB-1:0] idx_ff;
   logic          hit_ff,  free_ff,  ot_ff,  oa_ff;
   logic [IB-1:0] hit_idx_ff, free_idx_ff, ot_idx_ff, oa_idx_ff;
   logic [TB-1:0] ot_stamp_ff, oa_stamp_ff;

   logic                     rsp_valid_ff;
   logic [OUT_DATA_BITS_L-1:0] rsp_data_ff;

   // scanned entry
   logic          s_valid, s_temp, s_match;
   logic [TB-1:0] s_stamp;

   // commit decisions
   logic          full;
   logic          evict;
   logic [IB-1:0] tgt;
   logic [RB-1:0] tgt_out;
   logic [RB-1:0] victim_out;
   logic          victim_temp;

   assign s_valid = ent_valid_ff[idx_ff];
   assign s_temp  = ent_temp_ff[idx_ff];
   assign s_stamp = ent_stamp_ff[idx_ff];
   assign s_match = s_valid && !s_temp && !rq_temp_ff &&
                    (ent_var_ff[idx_ff] == rq_var_ff) &&
                    (ent_scope_ff[idx_ff] == rq_scope_ff);

   assign full        = (occ_ff >= CB'(N));
   assign evict       = !hit_ff && full;
   assign victim_temp = ot_ff;

   always_comb begin
      if (hit_ff)     tgt = hit_idx_ff;
      else if (!full) tgt = free_idx_ff;
      else if (ot_ff) tgt = ot_idx_ff;
      else            tgt = oa_idx_ff;
   end

   assign tgt_out    = RB'(tgt);
   assign victim_out = evict ? tgt_out : '0;

   assign status.scan_last = (idx_ff == IB'(N - 1));
   assign status.rsp_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // request capture and scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_temp_ff  <= req_tuser[0];
         rq_var_ff   <= req_tdata[VB-1:0];
         rq_scope_ff <= req_tdata[VB+SB-1:VB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         ot_ff   <= 1'b0;
         oa_ff   <= 1'b0;
      end else if (cmd.load) begin
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         ot_ff   <= 1'b0;
         oa_ff   <= 1'b0;
      end else if (cmd.step) begin
         idx_ff <= status.scan_last ? idx_ff : idx_ff + IB'(1);
         if (s_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (!s_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         // strict less-than keeps the lowest index on ties
         if (s_valid && s_temp && (!ot_ff || s_stamp < ot_stamp_ff)) begin
            ot_ff       <= 1'b1;
            ot_idx_ff   <= idx_ff;
            ot_stamp_ff <= s_stamp;
         end
         if (s_valid && (!oa_ff || s_stamp < oa_stamp_ff)) begin
            oa_ff       <= 1'b1;
            oa_idx_ff   <= idx_ff;
            oa_stamp_ff <= s_stamp;
         end
      end
   end

   // table update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            ent_valid_ff[i] <= 1'b0;
            ent_temp_ff[i]  <= 1'b0;
            ent_stamp_ff[i] <= '0;
         end
         use_clock_ff <= TB'(1);
         occ_ff       <= '0;
      end else if (cmd.commit) begin
         ent_stamp_ff[tgt] <= use_clock_ff;
         if (use_clock_ff != {TB{1'b1}}) use_clock_ff <= use_clock_ff + TB'(1);
         if (!hit_ff) begin
            ent_valid_ff[tgt] <= 1'b1;
            ent_temp_ff[tgt]  <= rq_temp_ff;
            // an eviction frees and refills the same entry
            if (!full) occ_ff <= occ_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff) begin
         ent_var_ff[tgt]   <= rq_temp_ff ? '0 : rq_var_ff;
         ent_scope_ff[tgt] <= rq_scope_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= OUT_DATA_BITS_L'({evict && victim_temp, victim_out,
                                          evict, hit_ff, tgt_out});
      end
   end

endmodule

FILE: rtl/lru_register_binding_table.sv
// ----------------------------------------------------------------------------
// lru_register_binding_table: register binding table with LRU replacement
// Top level: request sequencer plus table datapath on stream interfaces.
// ----------------------------------------------------------------------------
// Each request binds a named variable (var_id, scope_id) or a fresh temporary
// to one of NUM_REGS registers and returns exactly one result transfer. A
// request is accepted in the idle state, then a single scan steps through
// every entry of the table to find the match, the first free entry and the
// oldest temporary and oldest entry, and a commit state then writes the
// update. The scan is the only table read port, so it visits the entries
// in turn. The result sits in an output register, so a new request is taken
// while the previous result still waits; commit stalls only if that result
// is still untaken. When the table is full the oldest temporary is evicted,
// else the oldest entry, ties to the lowest index; the stamp clock saturates.
// ----------------------------------------------------------------------------
module lru_register_binding_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] var_id, [23:16] scope_id
   input  logic [lrbt_pkg::IN_DATA_BITS-1:0]   req_tdata,
   // [0] is_temp
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [4:0] reg_index, [5] hit, [6] evicted, [11:7] evicted_reg,
   // [12] evicted_was_temp, [15:13] zero
   output logic [lrbt_pkg::OUT_DATA_BITS-1:0]  rsp_tdata
);

   lrbt_pkg::lrbt_cmd_type    cmd;
   lrbt_pkg::lrbt_status_type status;

   lrbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lrbt_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/lrbt_checker.sv
// ----------------------------------------------------------------------------
// lrbt_checker: port-level checks for the binding table
// Result field consistency and request pacing, bound to the top level.
// ----------------------------------------------------------------------------
module lrbt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [lrbt_pkg::OUT_DATA_BITS-1:0]  rsp_tdata
);

   // a miss that evicts reuses the evicted register
   a_evict_reuse: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6]) |-> (rsp_tdata[4:0] == rsp_tdata[11:7]))
      else $error("evicting result does not reuse the evicted register");

   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[6]) |-> (rsp_tdata[11:7] == '0 && !rsp_tdata[12]))
      else $error("eviction fields set without an eviction");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[5] && rsp_tdata[6]))
      else $error("hit and eviction in one result");

   // one request in flight: the scan follows every accepted transfer
   a_req_pacing: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted during a scan");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result transfer changed");

endmodule

bind lru_register_binding_table lrbt_checker u_lrbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level test of lru_register_binding_table
// Drives variable and temporary binding requests and predicts the bound
// register, hit and eviction fields of every result transfer. Runs directed
// lookup, scope and eviction-order cases, a drained pause, and randomized
// traffic under varying sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS       = lrbt_pkg::NUM_REGS;
   localparam int VAR_ID_BITS    = lrbt_pkg::VAR_ID_BITS;
   localparam int SCOPE_ID_BITS  = lrbt_pkg::SCOPE_ID_BITS;
   localparam int STAMP_BITS     = lrbt_pkg::STAMP_BITS;
   localparam int REG_OUT_BITS   = lrbt_pkg::REG_OUT_BITS;
   localparam int IN_DATA_BITS   = lrbt_pkg::IN_DATA_BITS;
   localparam int OUT_FIELD_BITS = lrbt_pkg::OUT_FIELD_BITS;
   localparam int OUT_DATA_BITS  = lrbt_pkg::OUT_DATA_BITS;

   localparam int CYCLE_LIMIT = 400000;
   localparam int KEY_POOL    = 28;     // a few more keys than registers

   // result layout, lowest field last
   typedef struct packed {
      logic [OUT_DATA_BITS-OUT_FIELD_BITS-1:0] pad;
      logic                                    evicted_was_temp;
      logic [REG_OUT_BITS-1:0]                 evicted_reg;
      logic                                    evicted;
      logic                                    hit;
      logic [REG_OUT_BITS-1:0]                 reg_index;
   } binding_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [IN_DATA_BITS-1:0]   req_tdata = '0;
   logic [0:0]                req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [OUT_DATA_BITS-1:0]  rsp_tdata;

   // predicted table contents
   logic                      bound_valid [NUM_REGS];
   logic                      bound_temp  [NUM_REGS];
   logic [VAR_ID_BITS-1:0]    bound_var   [NUM_REGS];
   logic [SCOPE_ID_BITS-1:0]  bound_scope [NUM_REGS];
   logic [STAMP_BITS-1:0]     bound_stamp [NUM_REGS];
   logic [STAMP_BITS-1:0]     use_clock;
   int                        bound_count;

   binding_result_type        expected_bindings [$];
   int                        send_idle_pct;
   int                        recv_stall_pct;
   int                        error_count;
   int                        cycle_count;

   lru_register_binding_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string field, input int expected_value,
                                  input int observed_value);
      if (error_count < 50)
         $display("mismatch %s: expected %0d, got %0d (cycle %0d)",
                  field, expected_value, observed_value, cycle_count);
      error_count++;
   endtask

   function automatic logic [STAMP_BITS-1:0] take_use_stamp();
      logic [STAMP_BITS-1:0] stamp;
      stamp = use_clock;
      if (use_clock != '1) use_clock = use_clock + STAMP_BITS'(1);   // saturates
      return stamp;
   endfunction

   // LRU valid entry, temporaries only if asked; ties keep the lower index
   function automatic int oldest_binding(input logic temps_only);
      int best;
      best = -1;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (bound_valid[i] && (!temps_only || bound_temp[i])) begin
            if (best < 0 || bound_stamp[i] < bound_stamp[best]) best = i;
         end
      end
      return best;
   endfunction

   function automatic binding_result_type predict_binding(
         input logic temp, input logic [VAR_ID_BITS-1:0] var_id,
         input logic [SCOPE_ID_BITS-1:0] scope_id);
      binding_result_type res;
      int              slot;
      int              victim;
      res    = '0;
      slot   = -1;
      victim = -1;
      if (!temp) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if (slot < 0 && bound_valid[i] && !bound_temp[i] &&
                bound_var[i] == var_id && bound_scope[i] == scope_id) begin
               slot = i;
               bound_stamp[i] = take_use_stamp();
               res.hit = 1'b1;
            end
         end
      end
      if (!res.hit) begin
         if (bound_count >= NUM_REGS) begin
            victim = oldest_binding(1'b1);
            if (victim < 0) victim = oldest_binding(1'b0);
            res.evicted          = 1'b1;
            res.evicted_reg      = REG_OUT_BITS'(victim);
            res.evicted_was_temp = bound_temp[victim];
            bound_valid[victim]  = 1'b0;
            bound_temp[victim]   = 1'b0;
            bound_stamp[victim]  = '0;
            bound_count--;
         end
         for (int i = 0; i < NUM_REGS; i++) begin
            if (slot < 0 && !bound_valid[i]) slot = i;
         end
         bound_valid[slot] = 1'b1;
         bound_temp[slot]  = temp;
         bound_var[slot]   = temp ? '0 : var_id;
         bound_scope[slot] = scope_id;
         bound_stamp[slot] = take_use_stamp();
         bound_count++;
      end
      res.reg_index = REG_OUT_BITS'(slot);
      return res;
   endfunction

   // Called right after a rising edge; returns at the edge of the transfer.
   // tvalid stays high between back-to-back requests.
   task automatic send_request(input logic temp, input logic [VAR_ID_BITS-1:0] var_id,
                               input logic [SCOPE_ID_BITS-1:0] scope_id);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {scope_id, var_id};
      req_tuser  <= temp;
      do @(posedge clock); while (!req_tready);
      expected_bindings.push_back(predict_binding(temp, var_id, scope_id));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_bindings.size() != 0);
   endtask

   always @(posedge clock) begin
      binding_result_type observed;
      binding_result_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed = binding_result_type'(rsp_tdata);
         if (expected_bindings.size() == 0) begin
            report_mismatch("unexpected result transfer", 0, rsp_tdata);
         end else begin
            expected = expected_bindings.pop_front();
            if (observed.reg_index !== expected.reg_index)
               report_mismatch("reg_index", expected.reg_index, observed.reg_index);
            if (observed.hit !== expected.hit)
               report_mismatch("hit", expected.hit, observed.hit);
            if (observed.evicted !== expected.evicted)
               report_mismatch("evicted", expected.evicted, observed.evicted);
            if (observed.evicted_reg !== expected.evicted_reg)
               report_mismatch("evicted_reg", expected.evicted_reg, observed.evicted_reg);
            if (observed.evicted_was_temp !== expected.evicted_was_temp)
               report_mismatch("evicted_was_temp", expected.evicted_was_temp,
                               observed.evicted_was_temp);
            if (observed.pad !== expected.pad)
               report_mismatch("padding", expected.pad, observed.pad);
         end
      end
   end

   // hit refresh, field extremes, scope distinction, temporaries never match
   task automatic test_lookup_and_scope();
      send_request(1'b0, 16'h0000, 8'h00);
      send_request(1'b0, 16'hFFFF, 8'hFF);
      send_request(1'b0, 16'h0000, 8'h00);
      send_request(1'b1, 16'hFFFF, 8'hFF);
      send_request(1'b0, 16'hFFFF, 8'h00);
      send_request(1'b0, 16'h0000, 8'hFF);
   endtask

   // fill the table, then evict: oldest temp first, then oldest of any kind
   task automatic test_eviction_order();
      for (int k = 0; k < NUM_REGS - 5; k++)
         send_request(1'b0, 16'hA500 + 16'(k), 8'(8'h3C ^ k));
      send_request(1'b0, 16'h5A5A, 8'hC3);   // evicts the only temporary
      send_request(1'b0, 16'h1234, 8'h81);   // no temps: least recent variable
      send_request(1'b1, 16'h0000, 8'h00);   // temp request evicts a variable
      send_request(1'b1, 16'hFFFF, 8'hFF);   // now the temp just placed goes
   endtask

   // sender holds off until the table has answered everything
   task automatic test_paused_sender();
      send_request(1'b0, 16'h5A5A, 8'hC3);
      wait_for_results();
      send_request(1'b0, 16'h5A5A, 8'hC3);
      send_request(1'b0, 16'hA500, 8'h3C);
      wait_for_results();
      send_request(1'b1, 16'h7777, 8'h11);
   endtask

   task automatic test_random_traffic(input int count);
      logic [VAR_ID_BITS-1:0]   key_var   [KEY_POOL];
      logic [SCOPE_ID_BITS-1:0] key_scope [KEY_POOL];
      int                       temp_pct;
      int                       pick;
      temp_pct = 0;
      for (int k = 0; k < KEY_POOL; k++) begin
         // odd keys share the var id of their neighbor in another scope
         key_var[k]   = (k % 2 == 1) ? key_var[k-1] : VAR_ID_BITS'($urandom);
         key_scope[k] = SCOPE_ID_BITS'($urandom);
      end
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: temp_pct = 0;
               1: temp_pct = 5;
               2: temp_pct = 30;
               default: temp_pct = 70;
            endcase
         end
         pick = $urandom_range(0, KEY_POOL - 1);
         if ($urandom_range(0, 99) < temp_pct) begin
            send_request(1'b1, VAR_ID_BITS'($urandom), SCOPE_ID_BITS'($urandom));
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               key_var[pick]   = VAR_ID_BITS'($urandom);
               key_scope[pick] = SCOPE_ID_BITS'($urandom);
            end
            send_request(1'b0, key_var[pick], key_scope[pick]);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_REGS; i++) begin
         bound_valid[i] = 1'b0;
         bound_temp[i]  = 1'b0;
         bound_var[i]   = '0;
         bound_scope[i] = '0;
         bound_stamp[i] = '0;
      end
      use_clock      = 1;
      bound_count    = 0;
      error_count    = 0;
      cycle_count    = 0;
      send_idle_pct  = 29;
      recv_stall_pct = 87;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_lookup_and_scope();
      test_eviction_order();
      test_paused_sender();
      test_random_traffic(200);

      wait_for_results();
      send_idle_pct  = 87;
      recv_stall_pct = 29;
      test_random_traffic(200);

      wait_for_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_traffic(210);

      wait_for_results();
      repeat (NUM_REGS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
